[rtl/assert_macros.svh]
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define AVGP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define AVGP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/avgp_pkg.sv]
// shared types, constants and helpers of the 2x2 average pooling block
`default_nettype none

package avgp_pkg;

	localparam int PIX_W         = 8;
	localparam int PAIR_W        = 9;
	localparam int SUM_W         = 10;
	localparam int MULT_W        = 32;
	localparam int PROD_W        = 40;
	localparam int SHIFT_W       = 6;
	localparam int ROWW_W        = 13;
	localparam int ZP_W          = 8;
	localparam int DATA_W        = 32;
	localparam int ADDR_W        = 4;
	localparam int DEF_MAX_WIDTH = 4096;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_ROW_WIDTH   = 2'd0;
	localparam logic [1:0] REG_MULTIPLIER  = 2'd1;
	localparam logic [1:0] REG_RIGHT_SHIFT = 2'd2;
	localparam logic [1:0] REG_ZERO_POINT  = 2'd3;

	localparam logic [ROWW_W-1:0]  RST_ROW_WIDTH   = 13'd2;
	localparam logic [MULT_W-1:0]  RST_MULTIPLIER  = 32'd1;
	localparam logic [SHIFT_W-1:0] RST_RIGHT_SHIFT = 6'd0;
	localparam logic [ZP_W-1:0]    RST_ZERO_POINT  = 8'd0;

	typedef logic signed [PIX_W-1:0]  pix_t;
	typedef logic signed [PAIR_W-1:0] pair_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// settings seen by the output requantizer
	typedef struct packed {
		logic [SHIFT_W-1:0] right_shift;
		logic [ZP_W-1:0]    zero_point;
	} rq_cfg_t;

	// four-pixel sum divided by 4, truncating toward zero
	function automatic pix_t div4_trunc(input sum_t s);
		sum_t t;
		t = s[SUM_W-1] ? sum_t'(s + sum_t'(3)) : s;
		return t[SUM_W-1:2];
	endfunction

endpackage

`default_nettype wire

[rtl/avgp_pix_if.sv]
// pixel stream channel
`default_nettype none

interface avgp_pix_if;
	logic                         valid;
	logic                         ready;
	logic signed [avgp_pkg::PIX_W-1:0] pixel;
	logic                         frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

[rtl/avgp_pool_if.sv]
// pooled result channel
`default_nettype none

interface avgp_pool_if;
	logic                         valid;
	logic                         ready;
	logic signed [avgp_pkg::PIX_W-1:0] pooled_value;
	logic                         row_end;

	modport source (output valid, output pooled_value, output row_end, input ready);
	modport sink (input valid, input pooled_value, input row_end, output ready);
endinterface

`default_nettype wire

[rtl/avgp_line_ram.sv]
// line store of pair sums, one write and one registered read per cycle
`default_nettype none

module avgp_line_ram #(
	parameter int DEPTH = avgp_pkg::DEF_MAX_WIDTH / 2,
	parameter int AW    = 11
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [AW-1:0]                waddr,
	input  wire avgp_pkg::pair_t              wdata,
	input  wire logic                         re,
	input  wire logic [AW-1:0]                raddr,
	output avgp_pkg::pair_t                   rdata
);

	avgp_pkg::pair_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/avgp_requant.sv]
// rounding right shift, zero point and int8 saturation of one product
`default_nettype none

module avgp_requant (
	input  wire avgp_pkg::prod_t   prod,
	input  wire avgp_pkg::rq_cfg_t cfg,
	output avgp_pkg::pix_t         result
);

	localparam int MW = avgp_pkg::PROD_W + 1;
	localparam int RW = avgp_pkg::PROD_W + 2;

	logic                 neg;
	logic [MW-1:0]        mag;
	logic [MW-1:0]        half;
	logic [MW-1:0]        rounded;
	logic signed [RW-1:0] signed_q;
	logic signed [RW-1:0] biased;

	always_comb begin
		neg = prod[avgp_pkg::PROD_W-1];
		mag = neg ? MW'(-prod) : MW'(prod);
		mag[MW-1] = 1'b0;
		if (cfg.right_shift == '0) begin
			half = '0;
		end else begin
			half = MW'(1) << (cfg.right_shift - avgp_pkg::SHIFT_W'(1));
		end
		// magnitude stays below 2^39, so the rounded sum fits without carry out
		rounded  = (mag + half) >> cfg.right_shift;
		signed_q = neg ? -$signed(RW'(rounded)) : $signed(RW'(rounded));
		biased   = signed_q + RW'($signed(cfg.zero_point));
		if (biased > RW'(127)) begin
			result = avgp_pkg::pix_t'(127);
		end else if (biased < -$signed(RW'(128))) begin
			result = avgp_pkg::pix_t'(-128);
		end else begin
			result = biased[avgp_pkg::PIX_W-1:0];
		end
	end

endmodule

`default_nettype wire

[rtl/avgpool2x2_requant_int8.sv]
// top level of the int8 2x2 average pooling block with requantization
//
//  channel | role      | transfer moves
//  --------+-----------+-----------------------------------------------
//  pix     | sink      | one pixel (pixel, frame_start), raster order
//  pool    | source    | one window result (pooled_value, row_end)
//  apb     | slave     | register write/read, always ready
//
//  one pixel transfer per cycle, sustained while the pool output is not stalled; the line store
//  takes one write or one read per cycle, which sets that rate
//  a window result passes stage 1, stage 2 and stage 3 after the transfer of its last pixel,
//  is valid once it sits in the stage 3 output register and transfers while pool.ready is high
//  arst_n clears position, valid flags and registers; the line store has no
//  reset and is only read where the even row above wrote it
//  a stalled pool output backs up one stage at a time, pix.ready drops only
//  when every stage holds a result
`default_nettype none

module avgpool2x2_requant_int8 #(
	parameter int MAX_WIDTH = avgp_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [avgp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [avgp_pkg::DATA_W-1:0]   pwdata,
	output logic      [avgp_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	avgp_pix_if.sink                           pix,
	avgp_pool_if.source                        pool
);

`include "assert_macros.svh"

	// column counter, line store address and width compare sizes
	localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int LA         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int EW0        = $clog2(MAX_WIDTH + 1);
	localparam int EW         = (EW0 > avgp_pkg::ROWW_W) ? EW0 : avgp_pkg::ROWW_W;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [avgp_pkg::ROWW_W-1:0]  row_width_q;
	logic [avgp_pkg::MULT_W-1:0]  multiplier_q;
	logic [avgp_pkg::SHIFT_W-1:0] right_shift_q;
	logic [avgp_pkg::ZP_W-1:0]    zero_point_q;
	logic                         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q   <= avgp_pkg::RST_ROW_WIDTH;
			multiplier_q  <= avgp_pkg::RST_MULTIPLIER;
			right_shift_q <= avgp_pkg::RST_RIGHT_SHIFT;
			zero_point_q  <= avgp_pkg::RST_ZERO_POINT;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				avgp_pkg::REG_ROW_WIDTH:   row_width_q   <= pwdata[avgp_pkg::ROWW_W-1:0];
				avgp_pkg::REG_MULTIPLIER:  multiplier_q  <= pwdata[avgp_pkg::MULT_W-1:0];
				avgp_pkg::REG_RIGHT_SHIFT: right_shift_q <= pwdata[avgp_pkg::SHIFT_W-1:0];
				avgp_pkg::REG_ZERO_POINT:  zero_point_q  <= pwdata[avgp_pkg::ZP_W-1:0];
			endcase
		end
	end

	// register readback, zero extended
	always_comb begin
		unique case (paddr[3:2])
			avgp_pkg::REG_ROW_WIDTH:   prdata = avgp_pkg::DATA_W'(row_width_q);
			avgp_pkg::REG_MULTIPLIER:  prdata = avgp_pkg::DATA_W'(multiplier_q);
			avgp_pkg::REG_RIGHT_SHIFT: prdata = avgp_pkg::DATA_W'(right_shift_q);
			avgp_pkg::REG_ZERO_POINT:  prdata = avgp_pkg::DATA_W'(zero_point_q);
		endcase
	end

	// ---------------------------------------------------------------
	// pipeline flow: each stage moves when the next one is empty or moving
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	logic acc;

	assign en3       = !v_s3 || pool.ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign pix.ready = en1;
	assign acc       = pix.valid && en1;

	// ---------------------------------------------------------------
	// position tracking at the pixel transfer
	// ---------------------------------------------------------------
	logic [COL_W-1:0]  col_q;
	logic              odd_row_q;
	avgp_pkg::pix_t    held_q;

	logic [EW-1:0]     w_eff;
	logic [EW-1:0]     usable;
	logic [EW-1:0]     col_cur;
	logic [EW-1:0]     col_inc;
	logic              odd_cur;
	logic              in_row;
	logic              right_px;
	logic              line_we;
	logic              produce;
	logic              last_win;
	logic [LA-1:0]     line_idx;
	avgp_pkg::pair_t   pair_c;

	always_comb begin
		// width below 2 acts as 2, above the line store acts as its limit
		if (EW'(row_width_q) < EW'(2)) begin
			w_eff = EW'(2);
		end else if (EW'(row_width_q) > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(row_width_q);
		end
		usable   = {w_eff[EW-1:1], 1'b0};
		col_cur  = pix.frame_start ? '0 : EW'(col_q);
		odd_cur  = pix.frame_start ? 1'b0 : odd_row_q;
		col_inc  = col_cur + EW'(1);
		in_row   = col_cur < usable;
		right_px = in_row && col_cur[0];
		line_idx = LA'(col_cur >> 1);
		pair_c   = avgp_pkg::pair_t'(held_q) + avgp_pkg::pair_t'(pix.pixel);
		line_we  = acc && right_px && !odd_cur;
		produce  = right_px && odd_cur;
		last_win = col_inc == usable;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			odd_row_q <= 1'b0;
			held_q    <= '0;
		end else if (acc) begin
			if (in_row && !col_cur[0]) begin
				held_q <= pix.pixel;
			end
			// wrap once the column reaches the width
			if (col_inc >= w_eff) begin
				col_q     <= '0;
				odd_row_q <= !odd_cur;
			end else begin
				col_q     <= COL_W'(col_inc);
				odd_row_q <= odd_cur;
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 1: line store read of the pair sum from the row above
	// ---------------------------------------------------------------
	avgp_pkg::pair_t line_rd;
	avgp_pkg::pair_t pair_s1;
	logic            re_s1;

	avgp_line_ram #(
		.DEPTH (LINE_DEPTH),
		.AW    (LA)
	) u_line (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_idx),
		.wdata (pair_c),
		.re    (acc && produce),
		.raddr (line_idx),
		.rdata (line_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= acc && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && produce) begin
			pair_s1 <= pair_c;
			re_s1   <= last_win;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: window sum, divide by 4, multiply
	// ---------------------------------------------------------------
	avgp_pkg::sum_t  win_sum;
	avgp_pkg::pix_t  pool_avg;
	avgp_pkg::prod_t prod_c;
	avgp_pkg::prod_t prod_s2;
	logic            re_s2;

	assign win_sum  = avgp_pkg::sum_t'(line_rd) + avgp_pkg::sum_t'(pair_s1);
	assign pool_avg = avgp_pkg::div4_trunc(win_sum);
	assign prod_c   = avgp_pkg::prod_t'(pool_avg) * avgp_pkg::prod_t'($signed(multiplier_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			prod_s2 <= prod_c;
			re_s2   <= re_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: rounding shift, zero point, saturation into the output register
	// ---------------------------------------------------------------
	avgp_pkg::rq_cfg_t rq_cfg;
	avgp_pkg::pix_t    rq_val;
	avgp_pkg::pix_t    val_s3;
	logic              re_s3;

	assign rq_cfg.right_shift = right_shift_q;
	assign rq_cfg.zero_point  = zero_point_q;

	avgp_requant u_rq (
		.prod   (prod_s2),
		.cfg    (rq_cfg),
		.result (rq_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			val_s3 <= rq_val;
			re_s3  <= re_s2;
		end
	end

	assign pool.valid        = v_s3;
	assign pool.pooled_value = val_s3;
	assign pool.row_end      = re_s3;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	`AVGP_ASSERT(a_window_enters, (acc && produce) |=> v_s1, "window lost at stage 1")
	`AVGP_ASSERT_ALWAYS(a_no_write_on_read, !(line_we && produce), "line store written on an odd row")
	`AVGP_ASSERT(a_s1_holds, (v_s1 && !en2) |=> (v_s1 && $stable(pair_s1)), "stage 1 changed while stalled")
	`AVGP_ASSERT(a_col_range, EW'(col_q) < EW'(MAX_WIDTH), "column beyond line width")

endmodule

`default_nettype wire

[bench/avgp_window_check.sv]
`timescale 1ns / 100ps
// predicts each pooled window from the observed transfers and compares the results
module avgp_window_check
	import avgp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	avgp_pix_if               pix,
	avgp_pool_if              pool,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                mismatch_count,
	output int                windows_due,
	output int                windows_seen
);
	localparam int LINE_DEPTH = DEF_MAX_WIDTH / 2;

	typedef struct packed {
		pix_t value;
		logic row_end;
	} window_t;

	window_t due_windows[$];
	window_t oldest;

	// register mirror, updated from the config bus
	logic [ROWW_W-1:0]        row_width;
	logic signed [MULT_W-1:0] multiplier;
	logic [SHIFT_W-1:0]       right_shift;
	pix_t                     zero_point;

	// position and line store mirror
	pair_t       pair_line [LINE_DEPTH];
	pix_t        held_left;
	int unsigned column;
	logic        odd_row;

	initial begin
		mismatch_count = 0;
		windows_seen   = 0;
		windows_due    = 0;
	end

	// full precision product, rounding half away from zero, offset and clamp
	function automatic pix_t requant_window(input int pooled);
		longint          prod;
		longint unsigned mag;
		longint unsigned half;
		longint unsigned q;
		longint          r;
		prod = longint'(pooled) * longint'(multiplier);
		mag  = (prod < 0) ? -prod : prod;
		half = (right_shift == 0) ? 64'd0 : (64'd1 << (right_shift - 1));
		q    = (mag + half) >> right_shift;
		r    = (prod < 0) ? -longint'(q) : longint'(q);
		r    = r + longint'(zero_point);
		if (r > 127)
			r = 127;
		else if (r < -128)
			r = -128;
		return pix_t'(r);
	endfunction

	task automatic track_pixel(input pix_t px, input logic starts_frame);
		int unsigned w;
		int unsigned usable;
		int unsigned idx;
		int          pair;
		int          sum4;
		window_t     win;
		w = (row_width < 2) ? 2 : ((row_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : row_width);
		usable = w & ~32'd1;
		if (starts_frame) begin
			column  = 0;
			odd_row = 1'b0;
		end
		if (column < usable) begin
			idx = column >> 1;
			if ((column % 2) == 0) begin
				held_left = px;
			end else begin
				pair = int'(held_left) + int'(px);
				if (!odd_row) begin
					pair_line[idx] = pair_t'(pair);
				end else begin
					// division truncates toward zero
					sum4 = int'(pair_line[idx]) + pair;
					win.value   = requant_window(sum4 / 4);
					win.row_end = (column + 1 == usable);
					due_windows.push_back(win);
				end
			end
		end
		column++;
		if (column >= w) begin
			column  = 0;
			odd_row = ~odd_row;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width   = RST_ROW_WIDTH;
			multiplier  = RST_MULTIPLIER;
			right_shift = RST_RIGHT_SHIFT;
			zero_point  = RST_ZERO_POINT;
			held_left   = '0;
			column      = 0;
			odd_row     = 1'b0;
			due_windows.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_ROW_WIDTH:   row_width   = pwdata[ROWW_W-1:0];
					REG_MULTIPLIER:  multiplier  = pwdata[MULT_W-1:0];
					REG_RIGHT_SHIFT: right_shift = pwdata[SHIFT_W-1:0];
					REG_ZERO_POINT:  zero_point  = pwdata[ZP_W-1:0];
					default: ;
				endcase
			end
			// results leave registers after their last pixel, so check before predicting
			if (pool.valid && pool.ready) begin
				if (due_windows.size() == 0) begin
					mismatch_count++;
					$error("unexpected result: pooled_value %0d row_end %0b",
						$signed(pool.pooled_value), pool.row_end);
				end else begin
					oldest = due_windows.pop_front();
					windows_seen++;
					if (pool.pooled_value !== oldest.value) begin
						mismatch_count++;
						$error("pooled_value mismatch: expected %0d, got %0d",
							$signed(oldest.value), $signed(pool.pooled_value));
					end
					if (pool.row_end !== oldest.row_end) begin
						mismatch_count++;
						$error("row_end mismatch: expected %0b, got %0b",
							oldest.row_end, pool.row_end);
					end
				end
			end
			if (pix.valid && pix.ready)
				track_pixel(pix.pixel, pix.frame_start);
		end
		windows_due <= due_windows.size();
	end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// stimulus, register setup and verdict for the 2x2 average pooling block
module tb_top;
	import avgp_pkg::*;

	// receiver hold-off used to fill the pipeline and back up the pixel input
	localparam int LONG_HOLD = 400;
	// cycles after the last result for pixels still in flight
	localparam int SETTLE    = 8;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// idling knobs, percent of cycles
	int src_idle_pct     = 0;
	int sink_stall_pct   = 0;
	// each increment asks the receiver for one long hold
	int hold_requests    = 0;
	int pixels_sent      = 0;
	int settings_applied = 0;

	int mismatch_count;
	int windows_due;
	int windows_seen;

	avgp_pix_if  pix ();
	avgp_pool_if pool ();

	avgpool2x2_requant_int8 dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix     (pix),
		.pool    (pool)
	);

	avgp_window_check window_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.pix            (pix),
		.pool           (pool),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.windows_due    (windows_due),
		.windows_seen   (windows_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stalls, or a long hold whenever one is requested
	initial begin
		int hold_left;
		int holds_taken;
		hold_left   = 0;
		holds_taken = 0;
		pool.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_taken != hold_requests) begin
				holds_taken = hold_requests;
				hold_left   = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pool.ready <= 1'b0;
			end else begin
				pool.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// extremes show up often so that saturation and sign paths get hit
	function automatic pix_t rand_pixel();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return pix_t'(8'h7F);
		if (roll == 1)
			return pix_t'(8'h80);
		return pix_t'($urandom);
	endfunction

	// one pixel transfer, with random sender gaps ahead of it
	task automatic push_pixel(input pix_t value, input logic starts_frame);
		while ($urandom_range(99) < src_idle_pct) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid       <= 1'b1;
		pix.pixel       <= value;
		pix.frame_start <= starts_frame;
		do @(posedge clk); while (!pix.ready);
		pixels_sent++;
	endtask

	// a run of random pixels opening a new frame
	task automatic send_pixels(input int count);
		for (int i = 0; i < count; i++)
			push_pixel(rand_pixel(), i == 0);
	endtask

	// sender stops until every window is out, then lets the last pixels settle
	task automatic wait_quiet();
		pix.valid <= 1'b0;
		@(posedge clk);
		while (windows_due != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// setup cycle, then access cycle held until pready
	task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [ROWW_W-1:0] width, input logic [MULT_W-1:0] mult,
		input logic [SHIFT_W-1:0] shift, input logic [ZP_W-1:0] zp);
		wait_quiet();
		cfg_write(REG_ROW_WIDTH, DATA_W'(width));
		cfg_write(REG_MULTIPLIER, DATA_W'(mult));
		cfg_write(REG_RIGHT_SHIFT, DATA_W'(shift));
		cfg_write(REG_ZERO_POINT, DATA_W'(zp));
		settings_applied++;
	endtask

	// random settings, then whole frames with random content and some broken ones
	task automatic random_phase(input int src_pct, input int snk_pct, input int n_items);
		int                goal;
		int                roll;
		int                k;
		int                eff_w;
		int                len;
		logic [ROWW_W-1:0] w;
		logic [MULT_W-1:0] m;
		logic [SHIFT_W-1:0] s;
		goal           = pixels_sent + n_items;
		src_idle_pct   = src_pct;
		sink_stall_pct <= snk_pct;
		while (pixels_sent < goal) begin
			// widths: mostly narrow, a few clamped below 2, a few wider
			roll = $urandom_range(99);
			if (roll < 5)
				w = ROWW_W'($urandom_range(0, 1));
			else if (roll < 12)
				w = ROWW_W'($urandom_range(17, 96));
			else
				w = ROWW_W'($urandom_range(2, 16));
			// multiplier scaled to the shift so most outputs stay inside int8
			roll = $urandom_range(99);
			if (roll < 15) begin
				m = $urandom;
				s = SHIFT_W'($urandom_range(0, 63));
			end else begin
				k = $urandom_range(1, 31);
				m = $urandom >> (32 - k);
				if ($urandom_range(1) == 1)
					m = -m;
				s = SHIFT_W'(k + $urandom_range(0, 4));
			end
			apply_settings(w, m, s, ZP_W'($urandom));
			eff_w = (w < 2) ? 2 : int'(w);
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(4) != 0) begin
					// well formed frame, odd row counts leave a trailing row
					send_pixels(eff_w * ((eff_w > 16) ? 2 : $urandom_range(2, 6)));
				end else begin
					// broken frame: cut short and restarted at random places
					len = $urandom_range(1, 3 * eff_w);
					for (int i = 0; i < len; i++)
						push_pixel(rand_pixel(), i == 0 || $urandom_range(19) == 0);
				end
				if ($urandom_range(9) == 0)
					wait_quiet();
			end
		end
	endtask

	initial begin
		int drain_left;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		pix.valid       <= 1'b0;
		pix.pixel       <= '0;
		pix.frame_start <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// odd width of 5: last column dropped, full positive and full negative
		// windows reach the int8 limits, row_end on the second window, third row has no partner
		apply_settings(13'd5, 32'd1, 6'd0, 8'd0);
		push_pixel(pix_t'(8'h7F), 1'b1);
		push_pixel(pix_t'(8'h7F), 1'b0);
		push_pixel(pix_t'(8'h80), 1'b0);
		push_pixel(pix_t'(8'h80), 1'b0);
		push_pixel(pix_t'(8'd55), 1'b0);
		push_pixel(pix_t'(8'h7F), 1'b0);
		push_pixel(pix_t'(8'h7F), 1'b0);
		push_pixel(pix_t'(8'h80), 1'b0);
		push_pixel(pix_t'(8'h80), 1'b0);
		push_pixel(-8'sd7, 1'b0);
		push_pixel(pix_t'(8'd1), 1'b0);

		// most negative multiplier with the largest shift: magnitude rounds to zero
		apply_settings(13'd2, 32'h8000_0000, 6'd63, 8'd127);
		push_pixel(pix_t'(8'h80), 1'b1);
		push_pixel(pix_t'(8'h80), 1'b0);
		push_pixel(pix_t'(8'h80), 1'b0);
		push_pixel(pix_t'(8'h80), 1'b0);

		// most positive multiplier, wide product, lowest zero point
		apply_settings(13'd2, 32'h7FFF_FFFF, 6'd36, 8'h80);
		push_pixel(pix_t'(8'h7F), 1'b1);
		push_pixel(pix_t'(8'h7F), 1'b0);
		push_pixel(pix_t'(8'h7F), 1'b0);
		push_pixel(pix_t'(8'h7F), 1'b0);

		// width cut mid-row: an even row of 6 stops after column 4, width drops
		// to 2, the next pixel lies past the usable width and wraps the row
		apply_settings(13'd6, 32'd3, 6'd1, -8'sd5);
		push_pixel(pix_t'(8'd10), 1'b1);
		push_pixel(pix_t'(8'd20), 1'b0);
		push_pixel(pix_t'(8'd30), 1'b0);
		push_pixel(pix_t'(8'd40), 1'b0);
		push_pixel(pix_t'(8'd50), 1'b0);
		wait_quiet();
		cfg_write(REG_ROW_WIDTH, DATA_W'(2));
		push_pixel(pix_t'(8'd99), 1'b0);
		push_pixel(-8'sd1, 1'b0);
		push_pixel(-8'sd2, 1'b0);

		// back-pressure: receiver holds off while the sender keeps offering,
		// then the sender waits for every window before going on
		apply_settings(13'd8, 32'd1, 6'd0, 8'd0);
		hold_requests <= hold_requests + 1;
		send_pixels(8 * 12);
		wait_quiet();
		send_pixels(8 * 2);

		// a register value above the limit clamps to the widest row
		apply_settings(13'd8191, -32'sd3, 6'd2, 8'd10);
		send_pixels(100);

		// random part in each idling pattern
		random_phase(0, 0, 320);
		random_phase(76, 0, 320);
		random_phase(0, 76, 320);
		random_phase(7, 7, 320);

		// drain with a bound, then let the last pixels settle
		pix.valid <= 1'b0;
		@(posedge clk);
		drain_left = 20000;
		while (windows_due != 0 && drain_left > 0) begin
			@(posedge clk);
			drain_left--;
		end
		repeat (SETTLE) @(posedge clk);
		if (windows_due != 0)
			$error("%0d pooled results never arrived", windows_due);

		$display("covered %0d pixel transfers, %0d pooled windows checked, %0d register settings",
			pixels_sent, windows_seen, settings_applied);
		$display("idling: none, sender 76/100, receiver 76/100, both 7/100, one long receiver hold");
		if (mismatch_count == 0 && windows_due == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
